FILE: src/tcw_pkg.sv
package tcw_pkg;

  // Request item: one put or one cell read.
  typedef struct packed {
    logic       mode;
    logic [7:0] char_byte;
    logic [4:0] read_col;
    logic [4:0] read_row;
  } tcw_req_t;

  // Result item: one per request.
  typedef struct packed {
    logic [6:0] cell_tile;
    logic [7:0] cell_color;
    logic [4:0] cursor_col;
    logic [4:0] cursor_row;
  } tcw_rsp_t;

  localparam int unsigned TILE_W  = 7;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned INDEX_W = 2;

  // Configuration register indexes.
  localparam logic [INDEX_W-1:0] REG_FG_COLOR    = 2'd0;
  localparam logic [INDEX_W-1:0] REG_BG_COLOR    = 2'd1;
  localparam logic [INDEX_W-1:0] REG_TAB_SIZE    = 2'd2;
  localparam logic [INDEX_W-1:0] REG_WRAP_ENABLE = 2'd3;

  localparam logic [3:0] FG_RESET   = 4'd15;
  localparam logic [3:0] BG_RESET   = 4'd0;
  localparam logic [4:0] TAB_RESET  = 5'd4;
  localparam logic       WRAP_RESET = 1'b1;

  localparam logic       MODE_PUT  = 1'b0;
  localparam logic       MODE_READ = 1'b1;

  localparam logic [7:0] CHAR_TAB      = 8'h09;
  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
  localparam logic [7:0] CHAR_PRINT_HI = 8'h7E;

  localparam logic [TILE_W-1:0]  TILE_RESET  = 7'h00;
  localparam logic [TILE_W-1:0]  TILE_SPACE  = 7'h20;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h20;

endpackage

FILE: src/tcw_ram.sv
module tcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 840
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/text_console_writer.sv
// Text console writer: a ROWS x COLUMNS grid of cells, each a 7-bit tile and
// an 8-bit colour byte (background in the high nibble), kept in two RAMs.
// Request channel (req_valid/req_stall/req): an item either puts one byte at
// the text cursor or reads one cell. Every request yields exactly one result
// item on the response channel (rsp_valid/rsp_stall/rsp) carrying the cell
// contents for reads and the cursor position after the item.
// Configuration (wr_en/wr_index/wr_data) sets the colours, the tab spacing
// and line wrap; write it only while no item is in flight.
// Flow: a read passes the states DECODE, READ and DONE; a plain put passes
// DECODE, PUT and DONE; a tab adds a stepping search in state TAB; a put that
// scrolls passes SCROLL first, since scrolling moves a circular top-row
// pointer and rewrites only the new bottom row, one cell a cycle through the
// single RAM ports. One item is worked on at a time; the next is taken once
// the result sits in the output register.
// Reset: a clearing pass writes every cell (tile zero, colour 0x20) with
// req_stall held high; the cursor returns home.
// A stalled result stays in the output register; one further item may be
// accepted and worked on, and it waits until that register is free.
module text_console_writer #(
  parameter int unsigned COLUMNS = 28,
  parameter int unsigned ROWS    = 30
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  tcw_pkg::tcw_req_t                  req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output tcw_pkg::tcw_rsp_t                  rsp,
  input  logic                               wr_en,
  input  logic [tcw_pkg::INDEX_W-1:0]        wr_index,
  input  logic [tcw_pkg::CFG_W-1:0]          wr_data
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS + 1);
  localparam int unsigned RW    = $clog2(ROWS + 1);
  localparam int unsigned PW    = $clog2(ROWS);
  localparam int unsigned MW    = $clog2(COLUMNS + 32);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_PUT    = 3'd5;
  localparam logic [2:0] S_TAB    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]    state;
  logic [AW-1:0] clr_addr;
  tcw_pkg::tcw_req_t item;

  logic [3:0] fg_color;
  logic [3:0] bg_color;
  logic [4:0] tab_size;
  logic       wrap_enable;

  logic [CW-1:0] col;
  logic [RW-1:0] line;
  logic [PW-1:0] top;
  logic [CW-1:0] scroll_k;
  logic [AW-1:0] src_base;
  logic [AW-1:0] dst_base;
  logic [MW-1:0] tab_m;

  logic [tcw_pkg::TILE_W-1:0]  res_tile;
  logic [tcw_pkg::COLOR_W-1:0] res_color;

  logic                        tile_we;
  logic [AW-1:0]               tile_waddr;
  logic [tcw_pkg::TILE_W-1:0]  tile_wdata;
  logic [tcw_pkg::TILE_W-1:0]  tile_rdata;
  logic                        color_we;
  logic [AW-1:0]               color_waddr;
  logic [tcw_pkg::COLOR_W-1:0] color_wdata;
  logic [tcw_pkg::COLOR_W-1:0] color_rdata;
  logic [AW-1:0]               raddr;

  // Read coordinates are reduced modulo the grid size by constant tables.
  logic [CW-1:0] col_mod [32];
  logic [PW-1:0] row_mod [32];

  for (genvar g = 0; g < 32; g++) begin : g_mod
    assign col_mod[g] = CW'(g % COLUMNS);
    assign row_mod[g] = PW'(g % ROWS);
  end

  function automatic logic [PW-1:0] phys_row(logic [PW-1:0] top_v, logic [PW-1:0] r);
    logic [PW:0] sum;
    sum = {1'b0, top_v} + {1'b0, r};
    if (sum >= (PW+1)'(ROWS)) begin
      sum = sum - (PW+1)'(ROWS);
    end
    return sum[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] row_base(logic [PW-1:0] p);
    return AW'(int'(p) * COLUMNS);
  endfunction

  logic [7:0]    ch;
  logic          is_cr;
  logic          is_tab;
  logic          is_lf;
  logic          do_store;
  logic [AW-1:0] put_addr;
  logic [CW-1:0] col_adv;
  logic [4:0]    tab_eff;
  logic [MW-1:0] tab_m_next;
  logic          tab_stop;
  logic [CW-1:0] tab_col;
  logic [AW-1:0] read_addr;

  always_comb begin
    ch       = item.char_byte;
    is_cr    = (ch == tcw_pkg::CHAR_CR);
    is_tab   = (ch == tcw_pkg::CHAR_TAB);
    is_lf    = (ch == tcw_pkg::CHAR_LF);
    do_store = (ch >= tcw_pkg::CHAR_PRINT_LO) && (ch <= tcw_pkg::CHAR_PRINT_HI) &&
               (col < CW'(COLUMNS));
    put_addr = row_base(phys_row(top, line[PW-1:0])) + AW'(col);
    col_adv  = do_store ? col + CW'(1) : col;
    tab_eff  = (tab_size == 5'd0) ? 5'd1 : tab_size;
    tab_m_next = tab_m + MW'(tab_eff);
    tab_stop = (tab_m_next > MW'(col)) || (tab_m_next >= MW'(COLUMNS));
    tab_col  = (tab_m_next >= MW'(COLUMNS)) ? CW'(COLUMNS) : CW'(tab_m_next);
    read_addr = row_base(phys_row(top, row_mod[item.read_row])) +
                AW'(col_mod[item.read_col]);
  end

  always_comb begin
    tile_we     = 1'b0;
    tile_waddr  = put_addr;
    tile_wdata  = ch[tcw_pkg::TILE_W-1:0];
    color_we    = 1'b0;
    color_waddr = put_addr;
    color_wdata = {bg_color, fg_color};
    raddr       = read_addr;
    case (state)
      S_CLEAR: begin
        tile_we     = 1'b1;
        tile_waddr  = clr_addr;
        tile_wdata  = tcw_pkg::TILE_RESET;
        color_we    = 1'b1;
        color_waddr = clr_addr;
        color_wdata = tcw_pkg::COLOR_RESET;
      end
      S_SCROLL: begin
        // Copy colours of the old bottom row into the new one, writing each in
        // the cycle after its read; the new bottom row's tiles become spaces.
        raddr       = src_base + AW'(scroll_k);
        tile_we     = (scroll_k < CW'(COLUMNS));
        tile_waddr  = dst_base + AW'(scroll_k);
        tile_wdata  = tcw_pkg::TILE_SPACE;
        color_we    = (scroll_k != '0);
        color_waddr = dst_base + AW'(scroll_k) - AW'(1);
        color_wdata = color_rdata;
      end
      S_PUT: begin
        tile_we  = do_store && !is_tab && !is_cr;
        color_we = do_store && !is_tab && !is_cr;
      end
      default: begin
      end
    endcase
  end

  tcw_ram #(
    .WIDTH(tcw_pkg::TILE_W),
    .DEPTH(CELLS)
  ) u_tile_ram (
    .clk  (clk),
    .we   (tile_we),
    .waddr(tile_waddr),
    .wdata(tile_wdata),
    .raddr(raddr),
    .rdata(tile_rdata)
  );

  tcw_ram #(
    .WIDTH(tcw_pkg::COLOR_W),
    .DEPTH(CELLS)
  ) u_color_ram (
    .clk  (clk),
    .we   (color_we),
    .waddr(color_waddr),
    .wdata(color_wdata),
    .raddr(raddr),
    .rdata(color_rdata)
  );

  logic rsp_load;

  assign req_stall = (state != S_IDLE);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color    <= tcw_pkg::FG_RESET;
      bg_color    <= tcw_pkg::BG_RESET;
      tab_size    <= tcw_pkg::TAB_RESET;
      wrap_enable <= tcw_pkg::WRAP_RESET;
    end else if (wr_en) begin
      case (wr_index)
        tcw_pkg::REG_FG_COLOR:    fg_color    <= wr_data[3:0];
        tcw_pkg::REG_BG_COLOR:    bg_color    <= wr_data[3:0];
        tcw_pkg::REG_TAB_SIZE:    tab_size    <= wr_data[4:0];
        tcw_pkg::REG_WRAP_ENABLE: wrap_enable <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      col       <= '0;
      line      <= '0;
      top       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            item  <= req;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_tile  <= '0;
          res_color <= '0;
          if (item.mode == tcw_pkg::MODE_READ) begin
            state <= S_READ;
          end else if (line == RW'(ROWS)) begin
            line     <= RW'(ROWS - 1);
            dst_base <= row_base(top);
            src_base <= row_base((top == '0) ? PW'(ROWS - 1) : top - PW'(1));
            scroll_k <= '0;
            state    <= S_SCROLL;
          end else begin
            state <= S_PUT;
          end
        end
        S_READ: begin
          res_tile  <= tile_rdata;
          res_color <= color_rdata;
          state     <= S_DONE;
        end
        S_SCROLL: begin
          scroll_k <= scroll_k + CW'(1);
          if (scroll_k == CW'(COLUMNS)) begin
            top   <= (top == PW'(ROWS - 1)) ? '0 : top + PW'(1);
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (is_cr) begin
            col   <= '0;
            state <= S_DONE;
          end else if (is_tab) begin
            tab_m <= '0;
            state <= S_TAB;
          end else begin
            if (is_lf || (col_adv >= CW'(COLUMNS) && wrap_enable)) begin
              col  <= '0;
              line <= line + RW'(1);
            end else begin
              col <= col_adv;
            end
            state <= S_DONE;
          end
        end
        S_TAB: begin
          // Step through multiples of the tab size until one passes the
          // cursor or reaches the row end.
          tab_m <= tab_m_next;
          if (tab_stop) begin
            if (tab_col >= CW'(COLUMNS) && wrap_enable) begin
              col  <= '0;
              line <= line + RW'(1);
            end else begin
              col <= tab_col;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp.cell_tile  <= res_tile;
            rsp.cell_color <= res_color;
            rsp.cursor_col <= 5'(col);
            rsp.cursor_row <= 5'(line);
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: bench/tb_text_console_writer.sv
`timescale 1ns / 1ps

module tb_text_console_writer;

  localparam int unsigned COLUMNS = 28;
  localparam int unsigned ROWS = 30;
  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 96;
  localparam int unsigned IDLE_PCT = 29;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  tcw_pkg::tcw_req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  tcw_pkg::tcw_rsp_t rsp;
  logic wr_en = 1'b0;
  logic [tcw_pkg::INDEX_W-1:0] wr_index = tcw_pkg::REG_FG_COLOR;
  logic [tcw_pkg::CFG_W-1:0] wr_data = '0;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the screen, the cursor and the settings.
  logic [tcw_pkg::TILE_W-1:0] tile_img [CELLS];
  logic [tcw_pkg::COLOR_W-1:0] colour_img [CELLS];
  int unsigned col_pos;
  int unsigned row_pos;
  logic [3:0] fg_reg;
  logic [3:0] bg_reg;
  logic [4:0] tab_reg;
  logic wrap_reg;

  tcw_pkg::tcw_rsp_t expected_cells[$];
  int errors = 0;
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  typedef struct {
    tcw_pkg::tcw_req_t item;
    bit typed;
    tcw_pkg::tcw_rsp_t want;
  } console_row_t;

  console_row_t script[$];

  function automatic void console_clear();
    for (int i = 0; i < CELLS; i++) begin
      tile_img[i] = tcw_pkg::TILE_RESET;
      colour_img[i] = tcw_pkg::COLOR_RESET;
    end
    col_pos = 0;
    row_pos = 0;
    fg_reg = tcw_pkg::FG_RESET;
    bg_reg = tcw_pkg::BG_RESET;
    tab_reg = tcw_pkg::TAB_RESET;
    wrap_reg = tcw_pkg::WRAP_RESET;
  endfunction

  function automatic tcw_pkg::tcw_rsp_t console_step(tcw_pkg::tcw_req_t item);
    tcw_pkg::tcw_rsp_t res;
    int unsigned idx;
    int unsigned step;
    logic [7:0] ch;
    res = '0;
    if (item.mode == tcw_pkg::MODE_PUT) begin
      ch = item.char_byte;
      // A line feed or a wrap past the last row is only acted on by the next put.
      if (row_pos >= ROWS) begin
        row_pos = ROWS - 1;
        for (int i = 0; i < CELLS - COLUMNS; i++) begin
          tile_img[i] = tile_img[i + COLUMNS];
          colour_img[i] = colour_img[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++) tile_img[i] = tcw_pkg::TILE_SPACE;
      end
      if (ch == tcw_pkg::CHAR_CR) begin
        col_pos = 0;
      end else begin
        if (col_pos < COLUMNS && ch >= tcw_pkg::CHAR_PRINT_LO &&
            ch <= tcw_pkg::CHAR_PRINT_HI) begin
          idx = row_pos * COLUMNS + col_pos;
          tile_img[idx] = ch[6:0];
          colour_img[idx] = {bg_reg, fg_reg};
          col_pos++;
        end
        if (ch == tcw_pkg::CHAR_TAB) begin
          step = (tab_reg == 5'd0) ? 1 : int'(tab_reg);
          col_pos = ((col_pos + step) / step) * step;
          if (col_pos > COLUMNS) col_pos = COLUMNS;
        end
        if (ch == tcw_pkg::CHAR_LF || (col_pos >= COLUMNS && wrap_reg)) begin
          col_pos = 0;
          row_pos++;
        end
      end
    end else begin
      idx = (int'(item.read_row) % ROWS) * COLUMNS + (int'(item.read_col) % COLUMNS);
      res.cell_tile = tile_img[idx];
      res.cell_color = colour_img[idx];
    end
    res.cursor_col = col_pos[4:0];
    res.cursor_row = row_pos[4:0];
    return res;
  endfunction

  function automatic tcw_pkg::tcw_req_t put_req(logic [7:0] ch);
    tcw_pkg::tcw_req_t item;
    item = '0;
    item.mode = tcw_pkg::MODE_PUT;
    item.char_byte = ch;
    return item;
  endfunction

  function automatic tcw_pkg::tcw_req_t read_req(logic [4:0] col, logic [4:0] row);
    tcw_pkg::tcw_req_t item;
    item = '0;
    item.mode = tcw_pkg::MODE_READ;
    item.read_col = col;
    item.read_row = row;
    return item;
  endfunction

  function automatic tcw_pkg::tcw_rsp_t cell_rsp(logic [6:0] tile, logic [7:0] colour,
                                                 logic [4:0] col, logic [4:0] row);
    tcw_pkg::tcw_rsp_t res;
    res.cell_tile = tile;
    res.cell_color = colour;
    res.cursor_col = col;
    res.cursor_row = row;
    return res;
  endfunction

  // Mostly text with line breaks so that the screen scrolls often.
  function automatic tcw_pkg::tcw_req_t random_item();
    tcw_pkg::tcw_req_t item;
    int unsigned pick;
    item.mode = tcw_pkg::MODE_PUT;
    item.char_byte = 8'($urandom_range(255));
    item.read_col = 5'($urandom_range(31));
    item.read_row = 5'($urandom_range(31));
    pick = $urandom_range(99);
    if (pick < 27) item.mode = tcw_pkg::MODE_READ;
    else if (pick < 72) item.char_byte =
        8'($urandom_range(tcw_pkg::CHAR_PRINT_HI, tcw_pkg::CHAR_PRINT_LO));
    else if (pick < 84) item.char_byte = tcw_pkg::CHAR_LF;
    else if (pick < 89) item.char_byte = tcw_pkg::CHAR_CR;
    else if (pick < 95) item.char_byte = tcw_pkg::CHAR_TAB;
    return item;
  endfunction

  task automatic send_item(tcw_pkg::tcw_req_t item, bit typed, tcw_pkg::tcw_rsp_t want);
    tcw_pkg::tcw_rsp_t predicted;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    predicted = console_step(item);
    expected_cells.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (COLUMNS + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [tcw_pkg::INDEX_W-1:0] index,
                           logic [tcw_pkg::CFG_W-1:0] data);
    wr_en <= 1'b1;
    wr_index <= index;
    wr_data <= data;
    @(posedge clk);
    case (index)
      tcw_pkg::REG_FG_COLOR: fg_reg = data[3:0];
      tcw_pkg::REG_BG_COLOR: bg_reg = data[3:0];
      tcw_pkg::REG_TAB_SIZE: tab_reg = data;
      tcw_pkg::REG_WRAP_ENABLE: wrap_reg = data[0];
      default: ;
    endcase
  endtask

  task automatic set_console(logic [3:0] fg, logic [3:0] bg, logic [4:0] tab, logic wrap);
    write_reg(tcw_pkg::REG_FG_COLOR, {1'b0, fg});
    write_reg(tcw_pkg::REG_BG_COLOR, {1'b0, bg});
    write_reg(tcw_pkg::REG_TAB_SIZE, tab);
    write_reg(tcw_pkg::REG_WRAP_ENABLE, {4'd0, wrap});
    wr_en <= 1'b0;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Result side: checks every accepted item and drives its own stall.
  always @(posedge clk) begin
    tcw_pkg::tcw_rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
        if (expected_cells.size() == 0) begin
          $display("%0t: result with no item waiting, got %h", $time, rsp);
          errors++;
        end else begin
          want = expected_cells.pop_front();
          check_field("cell_tile", {1'b0, want.cell_tile}, {1'b0, rsp.cell_tile});
          check_field("cell_color", want.cell_color, rsp.cell_color);
          check_field("cursor_col", {3'd0, want.cursor_col}, {3'd0, rsp.cursor_col});
          check_field("cursor_row", {3'd0, want.cursor_row}, {3'd0, rsp.cursor_row});
        end
      end
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("tb_text_console_writer: FAIL");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    console_clear();
    script.push_back('{read_req(5'd0, 5'd0), 1'b1,
                       cell_rsp(tcw_pkg::TILE_RESET, tcw_pkg::COLOR_RESET, 5'd0, 5'd0)});
    // Out-of-range coordinates fold back into the grid.
    script.push_back('{read_req(5'd31, 5'd31), 1'b1,
                       cell_rsp(tcw_pkg::TILE_RESET, tcw_pkg::COLOR_RESET, 5'd0, 5'd0)});
    script.push_back('{put_req(tcw_pkg::CHAR_PRINT_LO), 1'b1, cell_rsp('0, '0, 5'd1, 5'd0)});
    script.push_back('{put_req(tcw_pkg::CHAR_PRINT_HI), 1'b1, cell_rsp('0, '0, 5'd2, 5'd0)});
    script.push_back('{put_req(8'h1F), 1'b1, cell_rsp('0, '0, 5'd2, 5'd0)});
    script.push_back('{put_req(8'h7F), 1'b1, cell_rsp('0, '0, 5'd2, 5'd0)});
    script.push_back('{put_req(8'hFF), 1'b1, cell_rsp('0, '0, 5'd2, 5'd0)});
    script.push_back('{put_req(8'h00), 1'b1, cell_rsp('0, '0, 5'd2, 5'd0)});
    script.push_back('{put_req(tcw_pkg::CHAR_TAB), 1'b1, cell_rsp('0, '0, 5'd4, 5'd0)});
    script.push_back('{put_req(tcw_pkg::CHAR_TAB), 1'b1, cell_rsp('0, '0, 5'd8, 5'd0)});
    script.push_back('{put_req(tcw_pkg::CHAR_CR), 1'b1, cell_rsp('0, '0, 5'd0, 5'd0)});
    script.push_back('{put_req(tcw_pkg::CHAR_LF), 1'b1, cell_rsp('0, '0, 5'd0, 5'd1)});
    script.push_back('{read_req(5'd1, 5'd0), 1'b1, cell_rsp(7'h7E, 8'h0F, 5'd0, 5'd1)});
    script.push_back('{read_req(5'd0, 5'd0), 1'b1,
                       cell_rsp(tcw_pkg::TILE_SPACE, 8'h0F, 5'd0, 5'd1)});
    script.push_back('{read_req(5'd2, 5'd0), 1'b1,
                       cell_rsp(tcw_pkg::TILE_RESET, tcw_pkg::COLOR_RESET, 5'd0, 5'd1)});
    script.push_back('{read_req(5'd27, 5'd29), 1'b1,
                       cell_rsp(tcw_pkg::TILE_RESET, tcw_pkg::COLOR_RESET, 5'd0, 5'd1)});
    // Tabs from column one up to the row end, which wraps to the next line.
    script.push_back('{put_req(8'h48), 1'b0, '0});
    repeat (7) script.push_back('{put_req(tcw_pkg::CHAR_TAB), 1'b0, '0});
    script.push_back('{read_req(5'd0, 5'd1), 1'b0, '0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_item(script[i].item, script[i].typed, script[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      idle_on = 1'b1;
      case (p)
        0: set_console(4'd0, 4'd15, 5'd0, 1'b0);
        1: begin
          set_console(4'd15, 4'd0, 5'd31, 1'b1);
          idle_on = 1'b0;
        end
        2: begin
          set_console(4'($urandom_range(15)), 4'($urandom_range(15)), 5'd28, 1'b0);
          hold_request = 1'b1;
        end
        3: set_console(4'($urandom_range(15)), 4'($urandom_range(15)), 5'd1, 1'b1);
        4: set_console(4'($urandom_range(15)), 4'($urandom_range(15)),
                       5'($urandom_range(31)), 1'($urandom_range(1)));
        default: set_console(4'd10, 4'd5, 5'd7, 1'b1);
      endcase
      repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, '0);
    end

    drain();
    if (errors == 0) begin
      $display("tb_text_console_writer: PASS");
    end else begin
      $display("tb_text_console_writer: FAIL");
    end
    $finish;
  end

endmodule
